### src/tlpw_pkg.sv
// Shared constants and types of the two-level page-walk MMU.
`timescale 1ns / 1ps
`default_nettype none
package tlpw_pkg;

    localparam int MEM_WORDS_LOG2_DEF = 14;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic CFG_PAGING_ENABLE   = 1'b0;
    localparam logic CFG_DIRECTORY_FRAME = 1'b1;

    localparam int CFG_DATA_W = 20;

    typedef struct packed {
        logic [31:0] read_data;
        logic        page_fault;
        logic        bus_error;
    } result_t;

endpackage
`default_nettype wire

### src/tlpw_req_if.sv
// Request channel: one virtual access per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface tlpw_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] virt_addr;
    logic [31:0] write_data;
    logic [1:0]  size_code;

    modport source (output valid, output command, output virt_addr,
                    output write_data, output size_code, input ready);
    modport sink   (input valid, input command, input virt_addr,
                    input write_data, input size_code, output ready);
endinterface
`default_nettype wire

### src/tlpw_rsp_if.sv
// Response channel: one result per access.
`timescale 1ns / 1ps
`default_nettype none
interface tlpw_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        page_fault;
    logic        bus_error;

    modport source (output valid, output read_data, output page_fault,
                    output bus_error, input ready);
    modport sink   (input valid, input read_data, input page_fault,
                    input bus_error, output ready);
endinterface
`default_nettype wire

### src/tlpw_mem.sv
// Single-port physical memory with byte enables and a registered read.
`timescale 1ns / 1ps
`default_nettype none
module tlpw_mem #(
    parameter int MEM_WORDS_LOG2 = tlpw_pkg::MEM_WORDS_LOG2_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic                      we,
    input  wire logic [3:0]                be,
    input  wire logic [MEM_WORDS_LOG2-1:0] addr,
    input  wire logic [31:0]               wdata,
    output logic      [31:0]               rdata
);
    localparam int DEPTH = 1 << MEM_WORDS_LOG2;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    if (be[b])
                    begin
                        mem[addr][8*b +: 8] <= wdata[8*b +: 8];
                    end
                end
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### src/tlpw_walker.sv
// Sequencer: translation per byte, then byte-wise data access to memory.
`timescale 1ns / 1ps
`default_nettype none
module tlpw_walker #(
    parameter int MEM_WORDS_LOG2 = tlpw_pkg::MEM_WORDS_LOG2_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         idle,
    input  wire logic                    command,
    input  wire logic [31:0]             virt_addr,
    input  wire logic [31:0]             write_data,
    input  wire logic [1:0]              size_code,
    input  wire logic                    paging_enable,
    input  wire logic [19:0]             directory_frame,
    output logic                         res_valid,
    input  wire logic                    res_take,
    output tlpw_pkg::result_t            res
);
    localparam int AW = MEM_WORDS_LOG2 + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_XLATE, S_PDE, S_PTE, S_ACC, S_RD, S_DONE
    } state_t;

    state_t                    state_reg;
    logic                      cmd_reg;
    logic [31:0]               va_reg;
    logic [31:0]               wd_reg;
    logic [1:0]                last_reg;
    logic [1:0]                idx_reg;
    logic [19:0]               frame_reg;
    logic [AW-1:0]             pa_reg [4];
    logic [31:0]               rd_reg;
    logic                      pf_reg;
    logic                      be_reg;

    logic                      mem_en;
    logic                      mem_we;
    logic [3:0]                mem_be;
    logic [MEM_WORDS_LOG2-1:0] mem_addr;
    logic [31:0]               mem_wdata;
    logic [31:0]               mem_rdata;

    logic [31:0] va_i;
    logic [31:0] pde_addr;
    logic [31:0] pte_addr;
    logic [31:0] direct_pa;
    logic [31:0] walk_pa;
    logic        reuse;
    logic [1:0]  lane;
    logic [7:0]  wbyte;

    tlpw_mem #(.MEM_WORDS_LOG2(MEM_WORDS_LOG2)) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .be    (mem_be),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        va_i      = va_reg + {30'd0, idx_reg};
        pde_addr  = {directory_frame, va_i[31:22], 2'b00};
        pte_addr  = {mem_rdata[31:12], va_i[21:12], 2'b00};
        reuse     = (idx_reg != 2'd0) && (va_i[31:12] == va_reg[31:12]);
        direct_pa = paging_enable ? {frame_reg, va_i[11:0]} : va_i;
        walk_pa   = {mem_rdata[31:12], va_i[11:0]};
        lane      = pa_reg[idx_reg][1:0];
        wbyte     = wd_reg[8*idx_reg +: 8];

        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_be    = 4'b0001 << lane;
        mem_addr  = pa_reg[idx_reg][AW-1:2];
        mem_wdata = {4{wbyte}};
        unique case (state_reg)
            S_XLATE:
            begin
                mem_addr = pde_addr[AW-1:2];
                mem_en   = paging_enable && !reuse && (pde_addr[31:AW] == '0);
            end
            S_PDE:
            begin
                mem_addr = pte_addr[AW-1:2];
                mem_en   = mem_rdata[0] && (pte_addr[31:AW] == '0);
            end
            S_ACC:
            begin
                mem_en = 1'b1;
                mem_we = (cmd_reg == tlpw_pkg::CMD_WRITE);
            end
            default:
            begin
                mem_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= command;
                        va_reg    <= virt_addr;
                        wd_reg    <= write_data;
                        last_reg  <= (size_code == tlpw_pkg::SIZE_BYTE) ? 2'd0 :
                                     (size_code == tlpw_pkg::SIZE_HALF) ? 2'd1 : 2'd3;
                        idx_reg   <= 2'd0;
                        rd_reg    <= '0;
                        pf_reg    <= 1'b0;
                        be_reg    <= 1'b0;
                        state_reg <= S_XLATE;
                    end
                end
                S_XLATE:
                begin
                    if (paging_enable && !reuse)
                    begin
                        if (pde_addr[31:AW] != '0)
                        begin
                            be_reg    <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_PDE;
                        end
                    end
                    else if (direct_pa[31:AW] != '0)
                    begin
                        be_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pa_reg[idx_reg] <= direct_pa[AW-1:0];
                        if (idx_reg == last_reg)
                        begin
                            idx_reg   <= 2'd0;
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                end
                S_PDE:
                begin
                    if (!mem_rdata[0])
                    begin
                        pf_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (pte_addr[31:AW] != '0)
                    begin
                        be_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_PTE;
                    end
                end
                S_PTE:
                begin
                    if (!mem_rdata[0])
                    begin
                        pf_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (walk_pa[31:AW] != '0)
                    begin
                        be_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pa_reg[idx_reg] <= walk_pa[AW-1:0];
                        if (idx_reg == 2'd0)
                        begin
                            frame_reg <= mem_rdata[31:12];
                        end
                        if (idx_reg == last_reg)
                        begin
                            idx_reg   <= 2'd0;
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_XLATE;
                        end
                    end
                end
                S_ACC:
                begin
                    if (cmd_reg == tlpw_pkg::CMD_WRITE)
                    begin
                        if (idx_reg == last_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    rd_reg[8*idx_reg +: 8] <= mem_rdata[8*lane +: 8];
                    if (idx_reg == last_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_ACC;
                    end
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.page_fault = pf_reg;
        res.bus_error  = be_reg;
        res.read_data  = (cmd_reg == tlpw_pkg::CMD_WRITE || pf_reg || be_reg) ? 32'd0 : rd_reg;
    end
endmodule
`default_nettype wire

### src/two_level_page_walk_mmu.sv
// Top level of the two-level page-walk MMU: configuration, sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none
// The block serves one 1, 2 or 4 byte access at a time against its own byte-addressed,
// little-endian physical memory of 4 << MEM_WORDS_LOG2 bytes. With paging enabled, each
// byte is translated through a page directory and a page table (two dependent memory
// reads); bytes on the same page as the first byte reuse its frame, while each byte
// on a following page walks again. All bytes are translated and checked before any
// data is touched, so a faulting write changes nothing. The data phase then handles
// one byte at a time on the single memory port, through S_ACC for a write and
// through S_ACC and S_RD for a read. An aligned word read with paging on walks the
// first byte through S_XLATE, S_PDE and S_PTE, passes each further byte through
// S_XLATE alone, reads each byte through S_ACC and S_RD, and hands the result to the
// output register from S_DONE. With paging off each byte passes only through S_XLATE.
// The result sits in an output register, so a finished result can wait there while
// the next request is taken. The memory content is undefined after reset until
// written, and there is no clearing pass.
// Configuration writes must be made only while no access is in flight.
module two_level_page_walk_mmu #(
    parameter int MEM_WORDS_LOG2 = tlpw_pkg::MEM_WORDS_LOG2_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    tlpw_req_if.sink                                 req,
    tlpw_rsp_if.source                               rsp,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [tlpw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    logic              paging_enable_reg;
    logic [19:0]       directory_frame_reg;
    logic              out_valid_reg;
    tlpw_pkg::result_t out_reg;

    logic              walk_idle;
    logic              res_valid;
    logic              res_take;
    tlpw_pkg::result_t res;

    // Configuration registers: written directly, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_enable_reg   <= 1'b0;
            directory_frame_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tlpw_pkg::CFG_PAGING_ENABLE:   paging_enable_reg   <= cfg_data[0];
                tlpw_pkg::CFG_DIRECTORY_FRAME: directory_frame_reg <= cfg_data;
                default:                       paging_enable_reg   <= paging_enable_reg;
            endcase
        end
    end

    // A request transfer starts the sequencer whenever it is idle.
    assign req.ready = walk_idle;

    tlpw_walker #(.MEM_WORDS_LOG2(MEM_WORDS_LOG2)) u_walker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (req.valid),
        .idle            (walk_idle),
        .command         (req.command),
        .virt_addr       (req.virt_addr),
        .write_data      (req.write_data),
        .size_code       (req.size_code),
        .paging_enable   (paging_enable_reg),
        .directory_frame (directory_frame_reg),
        .res_valid       (res_valid),
        .res_take        (res_take),
        .res             (res)
    );

    // The output register takes a finished result once it is empty or being drained.
    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_reg.read_data;
    assign rsp.page_fault = out_reg.page_fault;
    assign rsp.bus_error  = out_reg.bus_error;
endmodule
`default_nettype wire

### dv/tlpw_checker.sv
// Checker of the page-walk MMU: predicts every result from the accepted requests and compares.
`timescale 1ns / 1ps
module tlpw_checker #(
    parameter int MEM_WORDS_LOG2 = tlpw_pkg::MEM_WORDS_LOG2_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tlpw_req_if                               req,
    tlpw_rsp_if                               rsp,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [tlpw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                outstanding,
    output int                                errors
);
    import tlpw_pkg::*;

    localparam int MEM_WORDS = 1 << MEM_WORDS_LOG2;

    typedef enum logic [1:0] {WALK_OK, WALK_FAULT, WALK_BUS} walk_status_e;

    logic [31:0] shadow_mem [0:MEM_WORDS-1];
    logic        paging_on;
    logic [19:0] dir_frame;
    result_t     pending_results [$];

    initial begin
        for (int i = 0; i < MEM_WORDS; i++)
            shadow_mem[i] = '0;
        paging_on   = 1'b0;
        dir_frame   = '0;
        errors      = 0;
        outstanding = 0;
    end

    function automatic logic in_memory(input logic [31:0] pa);
        return (pa >> 2) < MEM_WORDS;
    endfunction

    // Translates one byte address; table entries are read from the shadow memory.
    function automatic walk_status_e walk_byte(input logic [31:0] va, output logic [31:0] pa);
        logic [31:0] entry_addr;
        logic [31:0] pde;
        logic [31:0] pte;
        pa = va;
        if (paging_on) begin
            entry_addr = {dir_frame, 12'h000} + {20'd0, va[31:22], 2'b00};
            if (!in_memory(entry_addr))
                return WALK_BUS;
            pde = shadow_mem[entry_addr[MEM_WORDS_LOG2+1:2]];
            if (!pde[0])
                return WALK_FAULT;
            entry_addr = {pde[31:12], 12'h000} + {20'd0, va[21:12], 2'b00};
            if (!in_memory(entry_addr))
                return WALK_BUS;
            pte = shadow_mem[entry_addr[MEM_WORDS_LOG2+1:2]];
            if (!pte[0])
                return WALK_FAULT;
            pa = {pte[31:12], va[11:0]};
        end
        if (!in_memory(pa))
            return WALK_BUS;
        return WALK_OK;
    endfunction

    // Performs one access on the shadow memory and returns its result.
    function automatic result_t access_result(input logic cmd, input logic [31:0] va,
                                              input logic [31:0] wd, input logic [1:0] sz);
        result_t      res;
        walk_status_e st;
        logic [31:0]  pa [4];
        int           len;
        int           w;
        res = '0;
        st  = WALK_OK;
        len = (sz == SIZE_BYTE) ? 1 : (sz == SIZE_HALF) ? 2 : 4;
        for (int i = 0; i < len && st == WALK_OK; i++)
            st = walk_byte(va + i, pa[i]);
        if (st == WALK_OK) begin
            for (int i = 0; i < len; i++) begin
                w = pa[i][MEM_WORDS_LOG2+1:2];
                if (cmd == CMD_WRITE)
                    shadow_mem[w][pa[i][1:0]*8 +: 8] = wd[i*8 +: 8];
                else
                    res.read_data[i*8 +: 8] = shadow_mem[w][pa[i][1:0]*8 +: 8];
            end
        end
        if (cmd == CMD_WRITE)
            res.read_data = '0;
        res.page_fault = (st == WALK_FAULT);
        res.bus_error  = (st == WALK_BUS);
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("tlpw_checker: %0t %s mismatch: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_PAGING_ENABLE)
                    paging_on = cfg_data[0];
                else
                    dir_frame = cfg_data;
            end
            if (rsp.valid && rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $display("tlpw_checker: %0t result transfer with nothing expected", $time);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report("read_data", rsp.read_data, want.read_data);
                    if (rsp.page_fault !== want.page_fault)
                        report("page_fault", rsp.page_fault, want.page_fault);
                    if (rsp.bus_error !== want.bus_error)
                        report("bus_error", rsp.bus_error, want.bus_error);
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(access_result(req.command, req.virt_addr,
                                                        req.write_data, req.size_code));
            outstanding = pending_results.size();
        end
    end
endmodule

### dv/tb.sv
// Testbench top of the page-walk MMU: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
    import tlpw_pkg::*;

    localparam int MEM_WORDS = 1 << MEM_WORDS_LOG2_DEF;
    // Far above the slowest correct run, with its sender gaps, receiver stalls and one
    // long receiver hold.
    localparam int CYCLE_LIMIT = 400000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    int                      outstanding;
    int                      errors;
    int                      cycles;

    tlpw_req_if req ();
    tlpw_rsp_if rsp ();

    two_level_page_walk_mmu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tlpw_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    // The stimulus side keeps its own view of the page layout it builds and of
    // which memory words hold data, so that no read ever touches a word that was
    // never written. Table words are all written during setup.
    logic        paging_on;
    logic [19:0] dir_frame;
    bit          word_written [0:MEM_WORDS-1];

    // Set by the stimulus to ask for one long hold of the result side; the
    // quiet flag turns all idling off for the last part of the run.
    bit squeeze_req;
    bit quiet;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: random bursts of stalls and acceptance, one long hold on request,
    // and steady acceptance once the run turns quiet.
    initial
    begin
        bit held;
        int n;
        held = 0;
        rsp.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !held)
            begin
                // Hold off long enough for the block to fill and stall its request side.
                held = 1;
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (quiet)
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 18);
                rsp.ready <= ($urandom % 3 != 0);
                repeat (n) @(posedge clk);
            end
        end
    end

    // Where a byte lands under the layout built during setup. Returns 0 when the
    // byte faults or lies outside memory, so that the access touches no data.
    function automatic logic layout_byte(input logic [31:0] va, output logic [31:0] pa);
        logic [9:0] dir;
        logic [9:0] pg;
        dir = va[31:22];
        pg  = va[21:12];
        pa  = va;
        if (paging_on)
        begin
            if (dir_frame == 20'hfffff)
                return 0;
            if (dir == 10'd0 && (pg <= 10'd4 || pg == 10'd7))
                pa = {12'd0, (pg == 10'd7) ? 8'hf : 8'h8 + pg[7:0], va[11:0]};
            else if (dir == 10'd1023 && pg >= 10'd1022)
                pa = {12'd0, (pg == 10'd1022) ? 8'hd : 8'he, va[11:0]};
            else
                return 0;
        end
        return (pa >> 2) < MEM_WORDS;
    endfunction

    task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        // Registers change only with nothing in flight; every access gives a result,
        // so a short pause after the last one is enough. The request side goes quiet
        // first so that the last transfer is not offered again.
        req.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PAGING_ENABLE)
            paging_on = value[0];
        else
            dir_frame = value;
    endtask

    // Offers one access and returns at the edge of its transfer. A read that would
    // touch unwritten data is turned into a write of the same bytes.
    task automatic send(input logic cmd, input logic [31:0] va, input logic [31:0] wd,
                        input logic [1:0] sz);
        logic [31:0] pa [4];
        logic        clean;
        int          len;
        len   = (sz == SIZE_BYTE) ? 1 : (sz == SIZE_HALF) ? 2 : 4;
        clean = 1;
        for (int i = 0; i < len; i++)
            if (!layout_byte(va + i, pa[i]))
                clean = 0;
        if (clean)
        begin
            for (int i = 0; i < len; i++)
                if (!word_written[pa[i] >> 2])
                    cmd = CMD_WRITE;
            if (cmd == CMD_WRITE)
                for (int i = 0; i < len; i++)
                    word_written[pa[i] >> 2] = 1;
        end
        if (!quiet && $urandom % 4 == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.virt_addr  <= va;
        req.write_data <= wd;
        req.size_code  <= sz;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic random_access();
        logic [31:0] va;
        logic [1:0]  sz;
        logic [11:0] offs;
        int          pick;
        pick = $urandom % 8;
        sz   = (pick < 2) ? SIZE_BYTE : (pick < 4) ? SIZE_HALF : (pick < 7) ? 2'd2 : 2'd3;
        // Land near the end of a page now and then so that accesses cross it.
        offs = ($urandom % 4 == 0) ? 12'hffc + $urandom_range(0, 3) : $urandom;
        if (!paging_on)
            va = ($urandom % 16 == 0) ? $urandom : 32'h8000 + $urandom_range(0, 32'h8003);
        else
        begin
            pick = $urandom % 8;
            if (pick < 5)
                va = {10'd0, 10'($urandom_range(0, 7)), offs};
            else if (pick == 5)
                va = {10'd1023, 10'(1022 + $urandom_range(0, 1)), offs};
            else
                va = {10'(pick - 5), 10'($urandom), offs};
        end
        send($urandom % 2, va, $urandom, sz);
    endtask

    // One setting per phase; the all-ones directory frame makes every walk fail.
    logic [CFG_DATA_W-1:0] phase_frame  [6] = '{20'hfffff, 20'd1, 20'd0, 20'hfffff,
                                                20'd0, 20'd1};
    logic                  phase_paging [6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    initial
    begin
        logic [31:0] base;
        rst_n          = 1'b0;
        cycles         = 0;
        paging_on      = 1'b0;
        dir_frame      = '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_PAGING_ENABLE;
        cfg_data       <= '0;
        req.valid      <= 1'b0;
        req.command    <= CMD_READ;
        req.virt_addr  <= '0;
        req.write_data <= '0;
        req.size_code  <= SIZE_BYTE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tables are built with paging off. The same directory sits in frames 0 and 1:
        // slot 0 points to a table at 0x2000, slot 1 is not present, slot 2 points to
        // a table beyond memory, and slot 1023 points to a table at 0x3000.
        for (int f = 0; f < 2; f++)
        begin
            base = f << 12;
            send(CMD_WRITE, base + 32'h000, 32'h0000_2001, 2'd2);
            send(CMD_WRITE, base + 32'h004, 32'h0000_3000, 2'd2);
            send(CMD_WRITE, base + 32'h008, 32'h0010_0001, 2'd2);
            send(CMD_WRITE, base + 32'hffc, 32'h0000_3001, 2'd2);
        end
        // Pages 0-4 map to frames 8-12, page 5 is not present, page 6 and page 8 map
        // beyond memory, page 7 maps to the last frame.
        for (int p = 0; p < 9; p++)
            send(CMD_WRITE, 32'h2000 + 4 * p,
                 (p == 5) ? 32'h9000 : (p == 6) ? 32'h0020_0001 : (p == 7) ? 32'hf001 :
                 (p == 8) ? 32'h0001_0001 : ((32'h8 + p) << 12) | 32'h1, 2'd2);
        send(CMD_WRITE, 32'h3ff8, 32'h0000_d001, 2'd2);
        send(CMD_WRITE, 32'h3ffc, 32'h0000_e001, 2'd2);
        for (int w = 0; w < 4; w++)
            word_written[w] = 1;
        // Short checks with paging off: a table read back, a split write that runs
        // off the end of memory, and the top byte of the address space.
        send(CMD_READ, 32'h0000_0000, 32'h0, 2'd2);
        send(CMD_WRITE, 32'h0000_ffff, 32'hffff_ffff, SIZE_HALF);
        send(CMD_READ, 32'hffff_ffff, 32'h0, SIZE_BYTE);

        write_cfg(CFG_DIRECTORY_FRAME, 20'd1);
        write_cfg(CFG_PAGING_ENABLE, 1'b1);
        // Translated checks: a full word written and read back, both kinds of page
        // fault, both kinds of bus error, a faulting split write that must leave
        // memory alone, and a wrapping split access, sent as a write since part of it was never written.
        send(CMD_WRITE, 32'h0000_0000, 32'hffff_ffff, 2'd2);
        send(CMD_READ,  32'h0000_0000, 32'h0, 2'd2);
        send(CMD_READ,  32'h0000_5000, 32'h0, SIZE_BYTE);
        send(CMD_READ,  32'h0040_0000, 32'h0, SIZE_BYTE);
        send(CMD_READ,  32'h0000_6000, 32'h0, SIZE_BYTE);
        send(CMD_READ,  32'h0080_0000, 32'h0, SIZE_BYTE);
        send(CMD_WRITE, 32'h0000_4ffe, 32'h1234_5678, 2'd2);
        send(CMD_READ,  32'h0000_4ffe, 32'h0, SIZE_HALF);
        send(CMD_READ,  32'hffff_fffe, 32'h0, 2'd2);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_cfg(CFG_PAGING_ENABLE, phase_paging[ph]);
            write_cfg(CFG_DIRECTORY_FRAME, phase_frame[ph]);
            quiet = (ph == 5);
            for (int n = 0; n < ((ph == 3) ? 40 : 125); n++)
            begin
                if (ph == 1 && n == 30)
                    squeeze_req = 1;
                random_access();
            end
        end
        req.valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
